// File: src/nqp_pkg.sv
// Package: shared types, codes and constants of the NVMe queue pair pointer engine.
package nqp_pkg;

	localparam int MAX_DEPTH = 1024;
	localparam int PTR_W     = 10;
	localparam int DEPTH_W   = 11;
	localparam int CNT_W     = 11;
	localparam int STAT_W    = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam int DEPTH_LIM = (MAX_DEPTH > 1024) ? 1024 : ((MAX_DEPTH < 2) ? 2 : MAX_DEPTH);

	localparam logic [DEPTH_W-1:0] DEPTH_RST = 11'd256;

	localparam logic REG_IDX_QUEUE_DEPTH = 1'b0;

	localparam logic ACT_SUBMIT = 1'b0;
	localparam logic ACT_POLL   = 1'b1;

	typedef enum logic [1:0] {
		RC_OK      = 2'd0,
		RC_FULL    = 2'd1,
		RC_NO_CPL  = 2'd2,
		RC_INVALID = 2'd3
	} result_code_t;

	typedef struct packed {
		logic               action;
		logic [CNT_W-1:0]   count;
		logic [STAT_W-1:0]  entry_status;
		logic [PTR_W-1:0]   entry_sq_head;
	} nqp_in_t;

	typedef struct packed {
		result_code_t       result_code;
		logic [PTR_W-1:0]   first_slot;
		logic [PTR_W-1:0]   sq_doorbell_value;
		logic [PTR_W-1:0]   cq_doorbell_value;
		logic [PTR_W-1:0]   cq_slot;
		logic [STAT_W-2:0]  completion_status;
		logic               doorbell_valid;
	} nqp_out_t;

endpackage

// File: src/nqp_cfg_regs.sv
// Module: APB-style configuration register file (queue depth).
module nqp_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nqp_pkg::ADDR_W-1:0]  paddr,
	input  logic [nqp_pkg::DATA_W-1:0]  pwdata,
	output logic [nqp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [nqp_pkg::DEPTH_W-1:0] queue_depth
);
	import nqp_pkg::*;

	logic [DEPTH_W-1:0] depth_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RST;
		end else if (wr_en && (paddr[2] == REG_IDX_QUEUE_DEPTH)) begin
			depth_q <= pwdata[DEPTH_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IDX_QUEUE_DEPTH: prdata = {{(DATA_W-DEPTH_W){1'b0}}, depth_q};
			default:             prdata = '0;
		endcase
	end

	assign queue_depth = depth_q;

endmodule

// File: src/nqp_engine.sv
// Module: queue pointer state and the single-pass submit/poll evaluation.
module nqp_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  nqp_pkg::nqp_in_t            item,
	input  logic [nqp_pkg::DEPTH_W-1:0] queue_depth,
	output nqp_pkg::nqp_out_t           result
);
	import nqp_pkg::*;

	localparam logic [DEPTH_W-1:0] LIM = DEPTH_W'(DEPTH_LIM);

	logic [PTR_W-1:0]   sq_tail_q, sq_head_q, cq_head_q;
	logic               phase_q;

	logic [DEPTH_W-1:0] depth;
	logic [PTR_W-1:0]   tail_rd, head_rd, cq_rd, esq_rd;
	logic [DEPTH_W-1:0] used, avail, nh_sum;
	logic [DEPTH_W:0]   nt_sum;
	logic [PTR_W-1:0]   nt, nh;
	logic               wrap;

	logic [PTR_W-1:0]   sq_tail_d, sq_head_d, cq_head_d;
	logic               phase_d;

	// effective depth: clamp into 2 .. DEPTH_LIM
	always_comb begin
		if (queue_depth < DEPTH_W'(2)) begin
			depth = DEPTH_W'(2);
		end else if (queue_depth > LIM) begin
			depth = LIM;
		end else begin
			depth = queue_depth;
		end
	end

	// pointers at or above the depth read as zero
	assign tail_rd = ({1'b0, sq_tail_q} < depth) ? sq_tail_q : '0;
	assign head_rd = ({1'b0, sq_head_q} < depth) ? sq_head_q : '0;
	assign cq_rd   = ({1'b0, cq_head_q} < depth) ? cq_head_q : '0;
	assign esq_rd  = ({1'b0, item.entry_sq_head} < depth) ? item.entry_sq_head : '0;

	assign used   = (tail_rd >= head_rd) ? ({1'b0, tail_rd} - {1'b0, head_rd})
	                                     : (depth - {1'b0, head_rd} + {1'b0, tail_rd});
	assign avail  = depth - DEPTH_W'(1) - used;

	assign nt_sum = {2'b00, tail_rd} + {1'b0, item.count};
	assign nt     = (nt_sum >= {1'b0, depth}) ? PTR_W'(nt_sum - {1'b0, depth})
	                                          : nt_sum[PTR_W-1:0];

	assign nh_sum = {1'b0, cq_rd} + DEPTH_W'(1);
	assign wrap   = (nh_sum >= depth);
	assign nh     = wrap ? '0 : nh_sum[PTR_W-1:0];

	always_comb begin
		result    = '0;
		result.result_code = RC_OK;
		sq_tail_d = sq_tail_q;
		sq_head_d = sq_head_q;
		cq_head_d = cq_head_q;
		phase_d   = phase_q;
		if (item.action == ACT_SUBMIT) begin
			if (item.count == '0) begin
				result.result_code = RC_INVALID;
			end else if (item.count > avail) begin
				result.result_code = RC_FULL;
			end else begin
				result.first_slot        = tail_rd;
				result.sq_doorbell_value = nt;
				result.doorbell_valid    = 1'b1;
				sq_tail_d                = nt;
			end
		end else begin
			result.cq_slot = cq_rd;
			if (item.entry_status[0] != phase_q) begin
				result.result_code = RC_NO_CPL;
			end else begin
				result.cq_doorbell_value = nh;
				result.completion_status = item.entry_status[STAT_W-1:1];
				result.doorbell_valid    = 1'b1;
				cq_head_d                = nh;
				sq_head_d                = esq_rd;
				phase_d                  = phase_q ^ wrap;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_tail_q <= '0;
			sq_head_q <= '0;
			cq_head_q <= '0;
			phase_q   <= 1'b1;
		end else if (advance) begin
			sq_tail_q <= sq_tail_d;
			sq_head_q <= sq_head_d;
			cq_head_q <= cq_head_d;
			phase_q   <= phase_d;
		end
	end

endmodule

// File: src/nvme_queue_pair_pointers_core.sv
// Top level: NVMe submission/completion queue pair pointer engine.
// One item per cycle sustained unless the output stalls. Each transfer on
// the input channel lands in an input register (s1); the pointer engine
// evaluates it in one pass and the result goes into the result register
// (s2) on the same edge that commits the new pointer state, so the next
// item in s1 already sees the updated state. A result thus passes through
// s1 and then s2 before it is offered on the result channel. The rate is
// set by the pointer compare/update loop in the engine; the input side
// stalls only while the result register holds an untaken result and s1
// is occupied. Queue depth is set through the APB port (byte address 0, 11
// bits, reset 256, clamped to 2..1024 on use); write it only while idle.
// A write to the depth never moves a pointer: pointers at or beyond the
// new depth read as zero.
module nvme_queue_pair_pointers_core (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  nqp_pkg::nqp_in_t           in_data,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output nqp_pkg::nqp_out_t          out_data,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [nqp_pkg::ADDR_W-1:0] paddr,
	input  logic [nqp_pkg::DATA_W-1:0] pwdata,
	output logic [nqp_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import nqp_pkg::*;

	logic               valid_s1;
	nqp_in_t            item_s1;
	logic               valid_s2;
	nqp_out_t           result_s2;
	nqp_out_t           result;
	logic [DEPTH_W-1:0] queue_depth;
	logic               out_free;
	logic               advance;

	// result register can take a new result when empty or being drained
	assign out_free = !valid_s2 || !out_stall;
	// s1 item commits its state update and moves into s2
	assign advance  = valid_s1 && out_free;
	// s1 can refill when empty or when its item moves on this edge
	assign in_stall = valid_s1 && !out_free;

	nqp_cfg_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.queue_depth (queue_depth)
	);

	nqp_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.queue_depth (queue_depth),
		.result      (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

// File: src/nqp_checker.sv
// Checker: port-level assertions for the queue pair pointer engine, with bind.
module nqp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input nqp_pkg::nqp_out_t  out_data
);
	import nqp_pkg::*;

	// stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	// an empty result register never backpressures the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// a fresh result comes from an earlier input transfer
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without matching input transfer");

	// doorbell only on a successful item
	a_doorbell_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.doorbell_valid |-> out_data.result_code == RC_OK)
		else $error("doorbell flagged on failed item");

	// a missed completion leaves the CQ doorbell and status clear
	a_no_cpl_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.result_code == RC_NO_CPL)
		|-> (out_data.cq_doorbell_value == '0) && (out_data.completion_status == '0))
		else $error("no-completion result carries completion data");

endmodule

bind nvme_queue_pair_pointers_core nqp_checker u_nqp_checker (.*);
